@@ design/number_range_list_parser_core_defines.svh @@
// Assertion macros shared by the number range list parser RTL.
// Depends on nothing; the including module must provide clk_i and rst_ni.
`ifndef NUMBER_RANGE_LIST_PARSER_CORE_DEFINES_SVH
`define NUMBER_RANGE_LIST_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define NRLP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define NRLP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/nrlp_pkg.sv @@
// Shared types and constants of the number range list parser.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package nrlp_pkg;

  localparam int unsigned ValW   = 31;
  localparam int unsigned CountW = 6;
  localparam int unsigned ChW    = 8;

  localparam logic [CountW-1:0] LIST_LIMIT = 6'd63;
  localparam logic [ValW-1:0]   ACC_MAX    = 31'h7FFF_FFFF;

  localparam logic [ChW-1:0] CH_COMMA = 8'h2C;
  localparam logic [ChW-1:0] CH_DASH  = 8'h2D;
  localparam logic [ChW-1:0] CH_ZERO  = 8'h30;
  localparam logic [ChW-1:0] CH_NINE  = 8'h39;

  localparam logic KIND_VALUE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_SYNTAX   = 2'd1,
    STAT_OVERFLOW = 2'd2
  } status_e;

  // Syntax position within one list entry.
  typedef enum logic [1:0] {
    MODE_FIRST = 2'd0,  // a first digit is required
    MODE_MORE  = 2'd1,  // inside a single number
    MODE_ONE   = 2'd2,  // after a dash, a digit is required
    MODE_RANGE = 2'd3   // inside a range end
  } parse_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_STATUS
  } ctrl_state_e;

  typedef struct packed {
    logic [ChW-1:0] ch;
    logic           end_of_text;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic [ValW-1:0]   value;
    logic [1:0]        status;
    logic [CountW-1:0] count;
    logic              last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;       // input transfer this cycle
    logic step;         // one range expansion step
    logic emit_status;  // load the end-of-text status result
    logic final_ok;     // a range value may carry the last flag
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;    // output register can take a result
    logic start_range;  // the offered item starts a range expansion
    logic is_eot;       // the offered item ends the text
    logic expand_done;  // the range expansion has nothing more to emit
  } dp_status_t;

endpackage

`default_nettype wire

@@ design/nrlp_dpath.sv @@
// Datapath of the number range list parser: parse registers, digit
// accumulator, range counter, list limit register and output register.
// Depends on nrlp_pkg and the shared assertion macro header.
`default_nettype none
`include "number_range_list_parser_core_defines.svh"

module nrlp_dpath (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  nrlp_pkg::in_item_t        in_data_i,
  input  nrlp_pkg::ctrl_cmd_t       cmd_i,
  output nrlp_pkg::dp_status_t      stat_o,
  input  wire                       cfg_valid_i,
  input  wire [nrlp_pkg::CountW-1:0] cfg_wdata_i,
  output logic                      out_valid_o,
  input  wire                       out_ready_i,
  output nrlp_pkg::out_item_t       out_data_o
);
  import nrlp_pkg::*;

  parse_mode_e       mode_q, mode_d;
  status_e           err_q, err_d;
  logic [ValW-1:0]   acc_q, acc_d;
  logic              have_q, have_d;
  logic              in_range_q, in_range_d;
  logic [ValW-1:0]   prev_q, prev_d;
  logic [CountW-1:0] count_q, count_d;
  logic [ValW:0]     v_q, v_d;
  logic [CountW-1:0] max_count_q;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic              load;
  logic              is_dig;
  logic [ValW+3:0]   acc_x10;
  logic [ValW-1:0]   acc_sat;
  logic              list_full;
  logic              range_empty;
  logic              do_single;
  logic              single_last;
  logic [CountW:0]   count_inc;

  // Character class and saturating decimal accumulate.
  assign is_dig  = in_data_i.ch inside {[CH_ZERO:CH_NINE]};
  assign acc_x10 = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
                 + {31'b0, in_data_i.ch[3:0]};
  assign acc_sat = (acc_x10 > {4'b0, ACC_MAX}) ? ACC_MAX : acc_x10[ValW-1:0];

  // Limit checks; the register range already caps the limit at the list maximum.
  assign count_inc   = {1'b0, count_q} + 7'd1;
  assign list_full   = count_q >= max_count_q;
  assign range_empty = v_q > {1'b0, acc_q};

  // Status toward the controller.
  assign stat_o.slot_free   = !out_valid_q || out_ready_i;
  assign stat_o.is_eot      = in_data_i.end_of_text;
  assign stat_o.start_range = (err_q == STAT_OK) &&
                              (in_data_i.end_of_text ? in_range_q :
                               (mode_q == MODE_RANGE && in_data_i.ch == CH_COMMA));
  assign stat_o.expand_done = range_empty || list_full;

  // Next-state logic of the parse registers and the output register.
  always_comb begin
    mode_d      = mode_q;
    err_d       = err_q;
    acc_d       = acc_q;
    have_d      = have_q;
    in_range_d  = in_range_q;
    prev_d      = prev_q;
    count_d     = count_q;
    v_d         = v_q;
    load        = 1'b0;
    out_d       = out_q;
    do_single   = 1'b0;
    single_last = 1'b0;

    if (cmd_i.accept) begin
      if (stat_o.start_range) begin
        v_d = {1'b0, prev_q} + {{ValW{1'b0}}, 1'b1};
      end
      if (in_data_i.end_of_text) begin
        if (err_q == STAT_OK && !in_range_q && have_q) begin
          do_single = 1'b1;
        end
      end else if (err_q == STAT_OK) begin
        case (mode_q)
          MODE_FIRST, MODE_ONE: begin
            if (is_dig) begin
              acc_d  = acc_sat;
              have_d = 1'b1;
              mode_d = (mode_q == MODE_FIRST) ? MODE_MORE : MODE_RANGE;
            end else begin
              err_d = STAT_SYNTAX;
            end
          end
          MODE_MORE: begin
            if (is_dig) begin
              acc_d  = acc_sat;
              have_d = 1'b1;
            end else if (in_data_i.ch == CH_COMMA) begin
              do_single   = 1'b1;
              single_last = 1'b1;
              mode_d      = MODE_FIRST;
            end else if (in_data_i.ch == CH_DASH) begin
              do_single   = 1'b1;
              single_last = 1'b1;
              in_range_d  = 1'b1;
              mode_d      = MODE_ONE;
            end else begin
              err_d = STAT_SYNTAX;
            end
          end
          MODE_RANGE: begin
            if (is_dig) begin
              acc_d  = acc_sat;
              have_d = 1'b1;
            end else if (in_data_i.ch == CH_COMMA) begin
              // The accumulator keeps the range end until expansion finishes.
              in_range_d = 1'b0;
              mode_d     = MODE_FIRST;
            end else begin
              err_d = STAT_SYNTAX;
            end
          end
          default: begin
            err_d = STAT_SYNTAX;
          end
        endcase
      end

      // A completed single number goes out unless the list is full.
      if (do_single) begin
        acc_d  = '0;
        have_d = 1'b0;
        if (list_full) begin
          err_d = STAT_OVERFLOW;
        end else begin
          load         = 1'b1;
          count_d      = count_inc[CountW-1:0];
          prev_d       = acc_q;
          out_d.kind   = KIND_VALUE;
          out_d.value  = acc_q;
          out_d.status = STAT_OK;
          out_d.count  = count_inc[CountW-1:0];
          out_d.last   = single_last;
        end
      end
    end else if (cmd_i.step) begin
      // One range value per step, or the end of the expansion.
      if (stat_o.expand_done) begin
        acc_d  = '0;
        have_d = 1'b0;
        if (!range_empty) begin
          err_d = STAT_OVERFLOW;
        end
      end else begin
        load         = 1'b1;
        count_d      = count_inc[CountW-1:0];
        prev_d       = v_q[ValW-1:0];
        v_d          = v_q + {{ValW{1'b0}}, 1'b1};
        out_d.kind   = KIND_VALUE;
        out_d.value  = v_q[ValW-1:0];
        out_d.status = STAT_OK;
        out_d.count  = count_inc[CountW-1:0];
        out_d.last   = cmd_i.final_ok &&
                       (v_q == {1'b0, acc_q} || count_inc >= {1'b0, max_count_q});
      end
    end else if (cmd_i.emit_status) begin
      // Status result, then the parse state starts over for the next text.
      load         = 1'b1;
      out_d.kind   = KIND_STATUS;
      out_d.value  = '0;
      out_d.status = err_q;
      out_d.count  = count_q;
      out_d.last   = 1'b1;
      mode_d       = MODE_FIRST;
      err_d        = STAT_OK;
      acc_d        = '0;
      have_d       = 1'b0;
      in_range_d   = 1'b0;
      prev_d       = '0;
      count_d      = '0;
    end

    out_valid_d = load || (out_valid_q && !out_ready_i);
  end

  // Control and parse state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_FIRST;
      err_q       <= STAT_OK;
      acc_q       <= '0;
      have_q      <= 1'b0;
      in_range_q  <= 1'b0;
      prev_q      <= '0;
      count_q     <= '0;
      max_count_q <= LIST_LIMIT;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      err_q       <= err_d;
      acc_q       <= acc_d;
      have_q      <= have_d;
      in_range_q  <= in_range_d;
      prev_q      <= prev_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        max_count_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers: range counter and output result.
  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Every value result advances the list count by exactly one.
  `NRLP_ASSERT_NXT(a_count_step, load && out_d.kind == KIND_VALUE,
    count_q == $past(count_q) + 6'd1, "value result without count advance")
  // A status result leaves a cleared parse state behind.
  `NRLP_ASSERT_NXT(a_status_clears, cmd_i.emit_status,
    count_q == '0 && err_q == STAT_OK && mode_q == MODE_FIRST,
    "parse state not cleared after status")
  // After an error, text bytes produce nothing.
  `NRLP_ASSERT_IMP(a_err_silent, cmd_i.accept && !in_data_i.end_of_text && err_q != STAT_OK,
    !load && err_d == err_q, "byte after error changed the result stream")

endmodule

`default_nettype wire

@@ design/nrlp_ctrl.sv @@
// Controller of the number range list parser: sequences input transfers,
// range expansion and the end-of-text status result.
// Depends on nrlp_pkg and the shared assertion macro header.
`default_nettype none
`include "number_range_list_parser_core_defines.svh"

module nrlp_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  nrlp_pkg::dp_status_t stat_i,
  output nrlp_pkg::ctrl_cmd_t  cmd_o
);
  import nrlp_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        eot_pend_q, eot_pend_d;
  logic        accept;

  assign accept = in_valid_i && in_ready_o;

  // Next state.
  always_comb begin
    state_d    = state_q;
    eot_pend_d = eot_pend_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          eot_pend_d = stat_i.is_eot;
          if (stat_i.start_range) begin
            state_d = ST_EXPAND;
          end else if (stat_i.is_eot) begin
            state_d = ST_STATUS;
          end
        end
      end
      ST_EXPAND: begin
        if (stat_i.slot_free && stat_i.expand_done) begin
          state_d = eot_pend_q ? ST_STATUS : ST_IDLE;
        end
      end
      ST_STATUS: begin
        if (stat_i.slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o        = 1'b0;
    cmd_o.accept      = 1'b0;
    cmd_o.step        = 1'b0;
    cmd_o.emit_status = 1'b0;
    cmd_o.final_ok    = !eot_pend_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = stat_i.slot_free;
        cmd_o.accept = in_valid_i && stat_i.slot_free;
      end
      ST_EXPAND: begin
        cmd_o.step = stat_i.slot_free;
      end
      ST_STATUS: begin
        cmd_o.emit_status = stat_i.slot_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      eot_pend_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      eot_pend_q <= eot_pend_d;
    end
  end

  // End of text without a range goes straight to the status result.
  `NRLP_ASSERT_NXT(a_eot_to_status, accept && stat_i.is_eot && !stat_i.start_range,
    state_q == ST_STATUS, "end of text did not lead to status")

endmodule

`default_nettype wire

@@ design/number_range_list_parser_core.sv @@
// Number range list parser: takes one text byte per input transfer (for
// example "2,3,4,8-10") and returns one result per listed value, ranges
// expanded, then a status result with the value count at end of text. A
// byte that emits nothing or one value is done when it is accepted; a
// comma that closes a range is accepted first, then the range counter loop
// emits one value per step and a closing step ends the expansion. End of
// text then loads the status result. All results pass through a
// single output register, so a stalled consumer holds the parser once that
// register is full. The list limit register (reset 63) is written through
// the cfg channel, which is always ready.
`default_nettype none

module number_range_list_parser_core (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  input  nrlp_pkg::in_item_t        in_data_i,
  output logic                      out_valid_o,
  input  wire                       out_ready_i,
  output nrlp_pkg::out_item_t       out_data_o,
  input  wire                       cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire [nrlp_pkg::CountW-1:0] cfg_wdata_i
);
  import nrlp_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  assign cfg_ready_o = 1'b1;

  // Sequencing of transfers, range expansion and status.
  nrlp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Parse state, accumulators and output register.
  nrlp_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_valid_i (cfg_valid_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ verif/number_range_list_parser_core_test.sv @@
// Self-checking testbench for number_range_list_parser_core: directed text strings, then
// random well-formed, broken and noise strings under several list limits and random stalls.
// Depends on nrlp_pkg and the number_range_list_parser_core RTL only.
`timescale 1ns / 1ps

module number_range_list_parser_core_test;
  import nrlp_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_ITEMS = 500;
  localparam int PHASE_ITEMS  = 64;
  localparam int PRINT_CAP    = 40;

  // Directed stimulus row: one input byte, with a hand-typed result where it is obvious.
  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t res;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  in_item_t          in_data = '0;
  logic              in_ready;
  logic              out_valid;
  logic              out_ready = 1'b1;
  out_item_t         out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CountW-1:0] cfg_wdata = '0;

  // Parser state as predicted by the testbench.
  parse_mode_e       lex_mode = MODE_FIRST;
  logic [ValW-1:0]   acc_num = '0;
  bit                acc_valid = 1'b0;
  bit                range_open = 1'b0;
  logic [ValW-1:0]   last_emitted = '0;
  logic [CountW-1:0] emitted_cnt = '0;
  status_e           str_status = STAT_OK;
  logic [CountW-1:0] list_max = LIST_LIMIT;

  out_item_t step_out[$];
  out_item_t pending_results[$];
  dir_row_t  dir_q[$];
  logic [7:0] text_q[$];

  bit calm = 1'b0;
  int n_err = 0;
  int n_seen = 0;
  int n_items = 0;
  int n_rand = 0;
  int n_strings = 0;
  int n_cfg = 0;
  int cycle_cnt = 0;
  int stall_left = 0;

  always #6 clk = ~clk;

  number_range_list_parser_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_wdata_i (cfg_wdata)
  );

  // Parser prediction.

  function automatic void record(logic kind, logic [ValW-1:0] v, status_e st);
    out_item_t r;
    r.kind   = kind;
    r.value  = v;
    r.status = st;
    r.count  = emitted_cnt;
    r.last   = 1'b0;
    step_out.push_back(r);
  endfunction

  // Emits one value unless the list is full, in which case overflow is flagged.
  function automatic bit take_value(logic [ValW-1:0] v);
    logic [CountW-1:0] lim;
    lim = (list_max > LIST_LIMIT) ? LIST_LIMIT : list_max;
    if (emitted_cnt >= lim) begin
      str_status = STAT_OVERFLOW;
      return 1'b0;
    end
    emitted_cnt  = emitted_cnt + 1'b1;
    last_emitted = v;
    record(KIND_VALUE, v, STAT_OK);
    return 1'b1;
  endfunction

  function automatic void flush_number();
    if (acc_valid) void'(take_value(acc_num));
    acc_num   = '0;
    acc_valid = 1'b0;
  endfunction

  // A range runs from the last emitted value plus one up to the end number.
  function automatic void flush_range();
    logic [ValW:0] v;
    logic [ValW:0] stop;
    bit            go;
    stop = {1'b0, acc_num};
    v    = {1'b0, last_emitted} + 1'b1;
    go   = 1'b1;
    while (go && v <= stop) begin
      go = take_value(v[ValW-1:0]);
      v  = v + 1'b1;
    end
    acc_num   = '0;
    acc_valid = 1'b0;
  endfunction

  // The accumulator saturates instead of wrapping.
  function automatic void push_digit(logic [3:0] d);
    logic [ValW+4:0] t;
    t = acc_num * 10 + d;
    acc_num   = (t > ACC_MAX) ? ACC_MAX : t[ValW-1:0];
    acc_valid = 1'b1;
  endfunction

  function automatic void restart_string();
    lex_mode     = MODE_FIRST;
    acc_num      = '0;
    acc_valid    = 1'b0;
    range_open   = 1'b0;
    last_emitted = '0;
    emitted_cnt  = '0;
    str_status   = STAT_OK;
  endfunction

  // Works out the results that one accepted byte causes, into step_out.
  function automatic void parse_byte(in_item_t it);
    bit        is_dig;
    out_item_t r;
    is_dig = (it.ch >= CH_ZERO) && (it.ch <= CH_NINE);
    step_out.delete();
    if (it.end_of_text) begin
      if (str_status == STAT_OK) begin
        if (range_open) flush_range();
        else flush_number();
      end
      record(KIND_STATUS, '0, str_status);
      restart_string();
    end else if (str_status == STAT_OK) begin
      case (lex_mode)
        MODE_FIRST, MODE_ONE: begin
          if (is_dig) begin
            push_digit(4'(it.ch - CH_ZERO));
            if (lex_mode == MODE_FIRST) lex_mode = MODE_MORE;
            else lex_mode = MODE_RANGE;
          end else begin
            str_status = STAT_SYNTAX;
          end
        end
        MODE_MORE: begin
          if (is_dig) begin
            push_digit(4'(it.ch - CH_ZERO));
          end else if (it.ch == CH_COMMA) begin
            flush_number();
            lex_mode = MODE_FIRST;
          end else if (it.ch == CH_DASH) begin
            flush_number();
            range_open = 1'b1;
            lex_mode   = MODE_ONE;
          end else begin
            str_status = STAT_SYNTAX;
          end
        end
        default: begin
          if (is_dig) begin
            push_digit(4'(it.ch - CH_ZERO));
          end else if (it.ch == CH_COMMA) begin
            flush_range();
            range_open = 1'b0;
            lex_mode   = MODE_FIRST;
          end else begin
            str_status = STAT_SYNTAX;
          end
        end
      endcase
    end
    if (step_out.size() > 0) begin
      r = step_out.pop_back();
      r.last = 1'b1;
      step_out.push_back(r);
    end
  endfunction

  // Stimulus helpers.

  function automatic out_item_t mk(logic kind, logic [ValW-1:0] v, status_e st,
                                   logic [CountW-1:0] cnt, logic lst);
    out_item_t r;
    r.kind   = kind;
    r.value  = v;
    r.status = st;
    r.count  = cnt;
    r.last   = lst;
    return r;
  endfunction

  task automatic add_row(logic [7:0] ch, logic eot, logic typed, out_item_t res);
    dir_row_t row;
    row.item.ch          = ch;
    row.item.end_of_text = eot;
    row.typed            = typed;
    row.res              = res;
    dir_q.push_back(row);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_row(s[i], 1'b0, 1'b0, '0);
  endtask

  function automatic void put_digits(logic [63:0] v);
    logic [7:0]  d[$];
    logic [63:0] x;
    logic [7:0]  dg;
    x = v;
    if (x == 0) d.push_back(CH_ZERO);
    while (x != 0) begin
      dg = 8'(x % 10);
      d.push_front(CH_ZERO + dg);
      x = x / 10;
    end
    foreach (d[i]) text_q.push_back(d[i]);
  endfunction

  // Appends a number to the text and returns roughly the value that it parses to.
  function automatic logic [63:0] put_number();
    logic [63:0] v;
    logic [7:0]  dg;
    int          k;
    if ($urandom_range(0, 9) == 0) text_q.push_back(CH_ZERO);
    case ($urandom_range(0, 9))
      0, 1: begin
        v = 64'($urandom);
        put_digits(v);
      end
      2: begin
        // Ten to thirteen digits, often past the saturation point.
        k  = $urandom_range(10, 13);
        dg = 8'($urandom_range(1, 9));
        text_q.push_back(CH_ZERO + dg);
        for (int i = 1; i < k; i++) begin
          dg = 8'($urandom_range(0, 9));
          text_q.push_back(CH_ZERO + dg);
        end
        v = 64'(ACC_MAX);
      end
      default: begin
        v = 64'($urandom_range(0, 99));
        put_digits(v);
      end
    endcase
    return v;
  endfunction

  // Offers one byte after a random gap and predicts its results once it is accepted.
  task automatic send_item(in_item_t it, logic typed, out_item_t want);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    parse_byte(it);
    if (typed) pending_results.push_back(want);
    else foreach (step_out[i]) pending_results.push_back(step_out[i]);
    n_items++;
  endtask

  // Builds one random string, mostly well-formed, and sends it with its end of text.
  task automatic send_string();
    int          r;
    int          n_ent;
    logic [63:0] a;
    logic [63:0] b;
    logic [7:0]  dg;
    in_item_t    it;
    text_q.delete();
    r = $urandom_range(0, 99);
    if (r < 88) begin
      n_ent = $urandom_range(1, 4);
      for (int i = 0; i < n_ent; i++) begin
        if (i > 0) text_q.push_back(CH_COMMA);
        a = put_number();
        if ($urandom_range(0, 99) < 35) begin
          text_q.push_back(CH_DASH);
          case ($urandom_range(0, 9))
            0: b = 64'($urandom_range(0, 200));
            1: b = (a > 2) ? a - 2 : 0;
            default: b = a + 64'($urandom_range(0, 5));
          endcase
          put_digits(b);
          // A dash after a range end is a syntax error.
          if ($urandom_range(0, 19) == 0) begin
            text_q.push_back(CH_DASH);
            put_digits(64'($urandom_range(0, 9)));
          end
        end
      end
      if ($urandom_range(0, 9) == 0) text_q.push_back($urandom_range(0, 1) ? CH_COMMA : CH_DASH);
      // Broken strings: one byte replaced by anything.
      if (r >= 70) text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
    end else begin
      repeat ($urandom_range(0, 6)) begin
        case ($urandom_range(0, 3))
          0: text_q.push_back(8'($urandom_range(0, 255)));
          1: begin
            dg = 8'($urandom_range(0, 9));
            text_q.push_back(CH_ZERO + dg);
          end
          2: text_q.push_back(CH_COMMA);
          default: text_q.push_back(CH_DASH);
        endcase
      end
    end
    foreach (text_q[i]) begin
      it.ch          = text_q[i];
      it.end_of_text = 1'b0;
      send_item(it, 1'b0, '0);
    end
    it.ch          = 8'($urandom_range(0, 255));
    it.end_of_text = 1'b1;
    send_item(it, 1'b0, '0);
    n_rand += text_q.size() + 1;
    n_strings++;
  endtask

  // Stops sending and waits until every predicted result has come back.
  task automatic drain(int extra);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CountW-1:0] v);
    cfg_valid <= 1'b1;
    cfg_wdata <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    list_max = v;
    n_cfg++;
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    n_err++;
    if (n_err <= PRINT_CAP)
      $display("result %0d: %s is %0h, expected %0h", n_seen, what, got, want);
  endtask

  // Result side: check each transfer against the oldest prediction, then stall at random.
  always @(posedge clk) begin : result_side
    out_item_t want;
    int        w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report("unexpected result value", out_data.value, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.kind !== want.kind) report("kind", out_data.kind, want.kind);
        if (out_data.value !== want.value) report("value", out_data.value, want.value);
        if (out_data.status !== want.status) report("status", out_data.status, want.status);
        if (out_data.count !== want.count) report("count", out_data.count, want.count);
        if (out_data.last !== want.last) report("last", out_data.last, want.last);
      end
      n_seen++;
      w = calm ? 0 : $urandom_range(0, 10);
      if (w > 0) begin
        out_ready  <= 1'b0;
        stall_left = w;
      end
    end else if (!out_ready) begin
      stall_left--;
      if (stall_left <= 0) out_ready <= 1'b1;
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("number_range_list_parser_core_test: errors");
    $finish;
  end

  initial begin : stimulus
    int                p;
    int                s;
    int                phase_start;
    logic [CountW-1:0] cfg_val;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed strings at the reset list limit.
    add_row(8'h5A, 1'b1, 1'b1, mk(KIND_STATUS, '0, STAT_OK, 0, 1'b1));
    add_text("0");
    add_row(CH_COMMA, 1'b0, 1'b1, mk(KIND_VALUE, '0, STAT_OK, 1, 1'b1));
    add_text("4294967296");
    add_row(CH_DASH, 1'b0, 1'b1, mk(KIND_VALUE, ACC_MAX, STAT_OK, 2, 1'b1));
    add_row(8'h00, 1'b1, 1'b1, mk(KIND_STATUS, '0, STAT_OK, 2, 1'b1));
    add_text("0");
    add_row(CH_DASH, 1'b0, 1'b1, mk(KIND_VALUE, '0, STAT_OK, 1, 1'b1));
    add_text("99");
    add_row(8'hFF, 1'b1, 1'b0, '0);
    add_text("5");
    add_row(CH_DASH, 1'b0, 1'b1, mk(KIND_VALUE, 5, STAT_OK, 1, 1'b1));
    add_text("3,");
    add_row(CH_DASH, 1'b0, 1'b0, '0);
    add_row(CH_NINE, 1'b1, 1'b1, mk(KIND_STATUS, '0, STAT_SYNTAX, 1, 1'b1));
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_text("7");
    add_row(8'h31, 1'b1, 1'b1, mk(KIND_STATUS, '0, STAT_SYNTAX, 0, 1'b1));
    foreach (dir_q[i]) send_item(dir_q[i].item, dir_q[i].typed, dir_q[i].res);

    // Random strings, one list limit per phase.
    p = 0;
    while (n_rand < RANDOM_ITEMS) begin
      drain(4);
      case (p % 8)
        0: cfg_val = 6'd1;
        1: cfg_val = LIST_LIMIT;
        2: cfg_val = 6'd2;
        4: cfg_val = LIST_LIMIT;
        5: cfg_val = 6'd5;
        7: cfg_val = 6'd3;
        default: cfg_val = 6'($urandom_range(1, 63));
      endcase
      write_cfg(cfg_val);
      calm = (p % 4 == 2);
      phase_start = n_rand;
      s = 0;
      while (n_rand - phase_start < PHASE_ITEMS && n_rand < RANDOM_ITEMS) begin
        // Once, hold the input until the output side has caught up.
        if (p == 1 && s == 4) drain(0);
        send_string();
        s++;
      end
      p++;
    end

    drain(100);
    $display("covered %0d input bytes in %0d random strings plus directed ones, %0d results",
             n_items, n_strings, n_seen);
    $display("list limit written %0d times between 1 and 63, with and without stalls", n_cfg);
    if (n_err == 0) begin
      $display("number_range_list_parser_core_test: clean");
    end else begin
      $display("number_range_list_parser_core_test: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/nrlp_pkg.sv
design/nrlp_dpath.sv
design/nrlp_ctrl.sv
design/number_range_list_parser_core.sv
verif/number_range_list_parser_core_test.sv
